// File: rtl/table_walk_byte_hash_core_macros.svh
// Assertion macros shared by the checker of the table walk byte hash core.
`ifndef TABLE_WALK_BYTE_HASH_CORE_MACROS_SVH
`define TABLE_WALK_BYTE_HASH_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define TWBH_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("twbh check failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define TWBH_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("twbh check failed");

`endif

// File: rtl/twbh_pkg.sv
// Types and constants shared by the table walk byte hash core.
`timescale 1ns / 1ps
`default_nettype none
package twbh_pkg;

    localparam int HASH_W      = 64;
    localparam int S_DATA_W    = 24;
    localparam int TABLE_DEPTH = 256;
    // Power of two, so the queue pointers wrap on their own.
    localparam int QUEUE_DEPTH = 2;

    // Codes carried in s_tuser.
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_KEY   = 2'd1;
    localparam logic [1:0] OP_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_BYTE,
        CMD_EMPTY
    } cmd_kind_t;

    // byte_a: table index for a load, key byte otherwise; byte_b: table value.
    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  byte_a;
        logic [7:0]  byte_b;
        logic        last;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_RD,
        ST_SEED_WR,
        ST_WALK_RD,
        ST_WALK_WR,
        ST_EMIT
    } back_state_t;

endpackage
`default_nettype wire

// File: rtl/twbh_front.sv
// Front end: takes input words, decodes the op code and pushes commands.
`timescale 1ns / 1ps
`default_nettype none
module twbh_front
    import twbh_pkg::*;
(
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic [1:0]          s_tuser,
    input  wire logic                s_tlast,
    input  wire logic                q_full,
    output logic                     push,
    output cmd_t                     push_cmd
);

    logic keep;

    assign s_tready = !q_full;

    // Unused op code: accept the word and drop it.
    always_comb
    begin
        keep            = 1'b1;
        push_cmd.kind   = CMD_BYTE;
        push_cmd.byte_a = s_tdata[23:16];
        push_cmd.byte_b = s_tdata[15:8];
        push_cmd.last   = s_tlast;
        unique case (s_tuser)
            OP_LOAD:
            begin
                push_cmd.kind   = CMD_LOAD;
                push_cmd.byte_a = s_tdata[7:0];
            end
            OP_KEY:
            begin
                push_cmd.kind = CMD_BYTE;
            end
            OP_EMPTY:
            begin
                push_cmd.kind = CMD_EMPTY;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = s_tvalid && s_tready && keep;

endmodule
`default_nettype wire

// File: rtl/twbh_queue.sv
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module twbh_queue
    import twbh_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    output logic      q_valid,
    output cmd_t      q_cmd,
    input  wire logic pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// File: rtl/twbh_back.sv
// Back end: substitution tables, lane walk sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
module twbh_back
    import twbh_pkg::*;
#(
    parameter int LANES = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire cmd_t              q_cmd,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [HASH_W-1:0]      m_tdata
);

    localparam int CNT_W = $clog2(LANES + 1);
    localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

    back_state_t      state_reg, state_next;
    logic [7:0]       lane_reg [LANES];
    logic [7:0]       prefix_reg [LANES];
    logic [7:0]       rd_data_reg [LANES];
    logic [7:0]       rd_addr [LANES];
    logic [CNT_W-1:0] bytes_seen_reg;
    logic [CNT_W-1:0] walk_idx_reg;
    logic [CNT_W-1:0] walk_cnt_reg;
    logic [CNT_W-1:0] seen_inc;
    logic             seeded_reg;
    logic             from_prefix_reg;
    logic             last_reg;
    logic             empty_reg;
    logic [7:0]       cur_byte_reg;
    logic             out_valid_reg;
    logic [HASH_W-1:0] out_data_reg;
    logic [HASH_W-1:0] lanes_packed;
    logic [7:0]       walk_byte;
    logic             slot_free;
    logic             reach;
    logic             walk_more;
    logic             take;
    logic             mem_we;
    logic             rd_en;
    logic             emit;

    assign seen_inc  = bytes_seen_reg + CNT_W'(1);
    assign reach     = (seen_inc >= CNT_W'(LANES)) || q_cmd.last;
    assign slot_free = !out_valid_reg || m_tready;
    assign walk_more = from_prefix_reg && (walk_idx_reg != walk_cnt_reg - CNT_W'(1));
    assign walk_byte = from_prefix_reg ? prefix_reg[walk_idx_reg[IDX_W-1:0]] : cur_byte_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_cmd.kind)
                        CMD_LOAD:
                        begin
                            state_next = ST_IDLE;
                        end
                        CMD_EMPTY:
                        begin
                            state_next = ST_EMIT;
                        end
                        CMD_BYTE:
                        begin
                            if (seeded_reg)
                            begin
                                state_next = ST_WALK_RD;
                            end
                            else if (reach)
                            begin
                                state_next = ST_SEED_RD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SEED_RD: state_next = ST_SEED_WR;
            ST_SEED_WR: state_next = ST_WALK_RD;
            ST_WALK_RD: state_next = ST_WALK_WR;
            ST_WALK_WR:
            begin
                priority if (walk_more)
                begin
                    state_next = ST_WALK_RD;
                end
                else if (last_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        q_pop  = 1'b0;
        mem_we = 1'b0;
        rd_en  = 1'b0;
        emit   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                q_pop  = q_valid;
                mem_we = q_valid && (q_cmd.kind == CMD_LOAD);
            end
            ST_SEED_RD, ST_WALK_RD:
            begin
                rd_en = 1'b1;
            end
            ST_EMIT:
            begin
                emit = slot_free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    assign take = q_pop && (q_cmd.kind == CMD_BYTE);

    // Seed reads at byte + LANES - n, walk reads at lane xor byte.
    always_comb
    begin
        for (int n = 0; n < LANES; n++)
        begin
            if (state_reg == ST_SEED_RD)
            begin
                rd_addr[n] = cur_byte_reg + 8'(LANES - n);
            end
            else
            begin
                rd_addr[n] = lane_reg[n] ^ walk_byte;
            end
        end
    end

    always_comb
    begin
        lanes_packed = '0;
        for (int n = 0; n < LANES; n++)
        begin
            lanes_packed[8*(LANES-1-n) +: 8] = lane_reg[n];
        end
    end

    // One table copy per lane: every load writes all copies.
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        logic [7:0] mem [TABLE_DEPTH];

        always_ff @(posedge clk)
        begin
            if (mem_we)
            begin
                mem[q_cmd.byte_a] <= q_cmd.byte_b;
            end
            if (rd_en)
            begin
                rd_data_reg[g] <= mem[rd_addr[g]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            bytes_seen_reg  <= '0;
            seeded_reg      <= 1'b0;
            walk_idx_reg    <= '0;
            walk_cnt_reg    <= '0;
            from_prefix_reg <= 1'b0;
            last_reg        <= 1'b0;
            empty_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop && (q_cmd.kind == CMD_EMPTY))
            begin
                empty_reg <= 1'b1;
            end
            if (take)
            begin
                empty_reg    <= 1'b0;
                last_reg     <= q_cmd.last;
                walk_idx_reg <= '0;
                if (seeded_reg)
                begin
                    from_prefix_reg <= 1'b0;
                end
                else
                begin
                    bytes_seen_reg  <= seen_inc;
                    walk_cnt_reg    <= seen_inc;
                    from_prefix_reg <= 1'b1;
                end
            end
            if (state_reg == ST_SEED_WR)
            begin
                seeded_reg <= 1'b1;
            end
            if (state_reg == ST_WALK_WR)
            begin
                walk_idx_reg <= walk_idx_reg + CNT_W'(1);
            end
            if (emit)
            begin
                out_valid_reg  <= 1'b1;
                bytes_seen_reg <= '0;
                seeded_reg     <= 1'b0;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_byte_reg <= q_cmd.byte_a;
            if (!seeded_reg)
            begin
                prefix_reg[bytes_seen_reg[IDX_W-1:0]] <= q_cmd.byte_a;
            end
        end
        if (state_reg == ST_SEED_WR || state_reg == ST_WALK_WR)
        begin
            for (int n = 0; n < LANES; n++)
            begin
                lane_reg[n] <= rd_data_reg[n];
            end
        end
        if (emit)
        begin
            out_data_reg <= empty_reg ? '1 : lanes_packed;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

// File: rtl/table_walk_byte_hash_core.sv
// Top level of the table walk byte hash core.
`timescale 1ns / 1ps
`default_nettype none
//
// Channel   Dir  Signals                          Contents
// s_*       in   tvalid tready tdata tuser tlast  table loads, key bytes, empty keys
// m_*       out  tvalid tready tdata              64-bit hash, one word per key
//
// The back end takes a table load, and a key byte that is only buffered,
// in its idle state. A byte on a seeded key is issued, then reads the
// tables and writes the lanes. The byte that seeds the lanes reads and
// writes the seed, then walks every buffered byte; the last byte loads the
// result register. Every lane step waits on its own synchronous table read.
// rst_n clears the sequencer, the queue and the result valid; the table
// holds whatever was last written. A stalled m side blocks only the back end:
// the front keeps taking words until the command queue fills.
//
module table_walk_byte_hash_core
    import twbh_pkg::*;
#(
    parameter int LANES = 8
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // [7:0] table_index, [15:8] table_value, [23:16] key_byte
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // [1:0] op
    input  wire logic [1:0]          s_tuser,
    input  wire logic                s_tlast,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [63:0] hash
    output logic [HASH_W-1:0]        m_tdata
);

    // Decoded commands from the front, drained by the back in order.
    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    twbh_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    twbh_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (q_pop)
    );

    // Back end: seed, walk and hold the result word until it is taken.
    twbh_back #(
        .LANES (LANES)
    ) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

// File: rtl/twbh_checker.sv
// Port checker for the table walk byte hash core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "table_walk_byte_hash_core_macros.svh"
module twbh_checker
    import twbh_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [HASH_W-1:0]   m_tdata
);

    // Queue starts empty: the front must take words right after reset.
    `TWBH_ASSERT_IMP(a_ready_after_reset, !$past(rst_n), s_tready)
    // No result can be pending straight out of reset.
    `TWBH_ASSERT_IMP(a_no_result_after_reset, !$past(rst_n), !m_tvalid)
    // Hold a refused result word.
    `TWBH_ASSERT_NXT(a_result_held, m_tvalid && !m_tready, m_tvalid)
    `TWBH_ASSERT_NXT(a_result_stable, m_tvalid && !m_tready, $stable(m_tdata))

endmodule

bind table_walk_byte_hash_core twbh_checker u_checker (.*);
`default_nettype wire
